// ----- src/lfupr_pkg.sv -----
// lfupr_pkg: shared types and fixed field widths for the lfu page replacement block
// used by lfupr_ctrl and lfu_page_replacement; depends on nothing
`default_nettype none

package lfupr_pkg;

   // widths of the request and response fields as seen on the ports
   localparam int REQ_PAGE_BITS = 16;
   localparam int RSP_PAGE_BITS = 16;
   localparam int RSP_OCC_BITS  = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_SHIFT,
      ST_APPEND,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                     hit;
      logic                     evicted;
      logic [RSP_PAGE_BITS-1:0] victim_page;
      logic [RSP_OCC_BITS-1:0]  occupancy;
   } result_type;

endpackage

`default_nettype wire

// ----- src/lfu_page_replacement.sv -----
// channel  | ports                                              | role
// req      | req_valid, req_ready, req_page_number              | page access word in
// rsp      | rsp_valid, rsp_ready, rsp_hit, rsp_evicted,         | one result word per access
//          | rsp_victim_page, rsp_occupancy                     |
//
// an access scans the used entries, then decides; an empty table goes straight to the
// append. a miss that evicts an entry ahead of the last closes up the later entries.
// the single read port of the frame table lets the scan read one entry per cycle.
// reset clears the state and the frame count, not the table, so no clearing pass is needed.
// a finished word waits in the output register while the next access is taken in.
//
// top level of the lfu page replacement block; depends on lfupr_pkg,
// lfupr_frame_ram and lfupr_ctrl
`default_nettype none

module lfu_page_replacement #(
   parameter int FRAMES     = 4,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [lfupr_pkg::REQ_PAGE_BITS-1:0]  req_page_number,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_hit,
   output logic                                      rsp_evicted,
   output logic      [lfupr_pkg::RSP_PAGE_BITS-1:0]  rsp_victim_page,
   output logic      [lfupr_pkg::RSP_OCC_BITS-1:0]   rsp_occupancy
);

   localparam int IDX_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int USED_BITS = $clog2(FRAMES + 1);
   localparam int WORD_BITS = PAGE_BITS + COUNT_BITS;

   logic                  mem_we;
   logic [IDX_BITS-1:0]   mem_waddr;
   logic [WORD_BITS-1:0]  mem_wdata;
   logic [IDX_BITS-1:0]   mem_raddr;
   logic [WORD_BITS-1:0]  mem_rdata;

   logic                  res_valid;
   logic                  out_free;
   lfupr_pkg::result_type res;

   logic                  rsp_valid_ff, rsp_valid_in;
   lfupr_pkg::result_type rsp_word_ff, rsp_word_in;

   lfupr_frame_ram #(
      .DEPTH     (FRAMES),
      .WIDTH     (WORD_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   lfupr_ctrl #(
      .FRAMES     (FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_BITS   (IDX_BITS),
      .USED_BITS  (USED_BITS),
      .WORD_BITS  (WORD_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_page_number (req_page_number),
      .res_valid       (res_valid),
      .res_free        (out_free),
      .res             (res),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata)
   );

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_word_ff.hit;
   assign rsp_evicted     = rsp_word_ff.evicted;
   assign rsp_victim_page = rsp_word_ff.victim_page;
   assign rsp_occupancy   = rsp_word_ff.occupancy;

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("hit and eviction reported together");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted) |-> (rsp_victim_page == '0))
      else $error("victim page set without an eviction");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new access taken while one is in progress");

endmodule

`default_nettype wire

// ----- src/lfupr_frame_ram.sv -----
// lfupr_frame_ram: frame table memory, one write port and one registered read port
// standalone, no package dependency
`default_nettype none

module lfupr_frame_ram #(
   parameter int DEPTH     = 4,
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 2
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/lfupr_ctrl.sv -----
// lfupr_ctrl: sequencer that scans the frame table, picks the victim and closes up entries
// depends on lfupr_pkg; drives the ports of lfupr_frame_ram
`default_nettype none

module lfupr_ctrl #(
   parameter int FRAMES     = 4,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16,
   parameter int IDX_BITS   = (FRAMES > 1) ? $clog2(FRAMES) : 1,
   parameter int USED_BITS  = $clog2(FRAMES + 1),
   parameter int WORD_BITS  = PAGE_BITS + COUNT_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [lfupr_pkg::REQ_PAGE_BITS-1:0] req_page_number,
   output logic                                    res_valid,
   input  wire logic                               res_free,
   output lfupr_pkg::result_type                   res,
   output logic                                    mem_we,
   output logic      [IDX_BITS-1:0]                mem_waddr,
   output logic      [WORD_BITS-1:0]               mem_wdata,
   output logic      [IDX_BITS-1:0]                mem_raddr,
   input  wire logic [WORD_BITS-1:0]               mem_rdata
);

   localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(FRAMES - 1);
   localparam logic [USED_BITS-1:0]  FULL      = USED_BITS'(FRAMES);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   lfupr_pkg::state_type   state_ff, state_in;
   logic [USED_BITS-1:0]   used_ff, used_in;
   logic [IDX_BITS-1:0]    scan_idx_ff, scan_idx_in;
   logic                   cmp_pending_ff, cmp_pending_in;
   logic [IDX_BITS-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [PAGE_BITS-1:0]   page_ff, page_in;
   logic                   hit_ff, hit_in;
   logic [IDX_BITS-1:0]    hit_idx_ff, hit_idx_in;
   logic [COUNT_BITS-1:0]  hit_cnt_ff, hit_cnt_in;
   logic                   min_valid_ff, min_valid_in;
   logic [IDX_BITS-1:0]    min_idx_ff, min_idx_in;
   logic [COUNT_BITS-1:0]  min_cnt_ff, min_cnt_in;
   logic [PAGE_BITS-1:0]   min_page_ff, min_page_in;
   logic [IDX_BITS-1:0]    shift_idx_ff, shift_idx_in;
   lfupr_pkg::result_type  res_ff, res_in;

   logic [PAGE_BITS-1:0]   rd_page;
   logic [COUNT_BITS-1:0]  rd_cnt;
   logic [USED_BITS-1:0]   used_inc;
   logic [IDX_BITS-1:0]    shift_next;
   logic [COUNT_BITS-1:0]  cnt_sat;
   logic                   scan_last;
   logic                   full;

   assign rd_page    = mem_rdata[WORD_BITS-1:COUNT_BITS];
   assign rd_cnt     = mem_rdata[COUNT_BITS-1:0];
   assign used_inc   = used_ff + USED_BITS'(1);
   assign shift_next = shift_idx_ff + IDX_BITS'(1);
   assign cnt_sat    = (hit_cnt_ff == COUNT_MAX) ? hit_cnt_ff : hit_cnt_ff + COUNT_ONE;
   assign scan_last  = ((USED_BITS'(scan_idx_ff) + USED_BITS'(1)) == used_ff);
   assign full       = (used_ff == FULL);
   assign res        = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lfupr_pkg::ST_IDLE;
         used_ff        <= '0;
         cmp_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         used_ff        <= used_in;
         cmp_pending_ff <= cmp_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      page_ff      <= page_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_cnt_ff   <= hit_cnt_in;
      min_valid_ff <= min_valid_in;
      min_idx_ff   <= min_idx_in;
      min_cnt_ff   <= min_cnt_in;
      min_page_ff  <= min_page_in;
      shift_idx_ff <= shift_idx_in;
      res_ff       <= res_in;
   end

   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_pending_in = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      page_in        = page_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_cnt_in     = hit_cnt_ff;
      min_valid_in   = min_valid_ff;
      min_idx_in     = min_idx_ff;
      min_cnt_in     = min_cnt_ff;
      min_page_in    = min_page_ff;
      shift_idx_in   = shift_idx_ff;
      res_in         = res_ff;
      mem_we         = 1'b0;
      mem_waddr      = hit_idx_ff;
      mem_wdata      = {page_ff, COUNT_ONE};
      mem_raddr      = scan_idx_ff;
      req_ready      = 1'b0;
      res_valid      = 1'b0;

      // read data of the previous scan address: match and least-count tracking
      if (cmp_pending_ff) begin
         if (!hit_ff && (rd_page == page_ff)) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
            hit_cnt_in = rd_cnt;
         end
         // strict less keeps the oldest entry on a tie
         if (!min_valid_ff || (rd_cnt < min_cnt_ff)) begin
            min_valid_in = 1'b1;
            min_idx_in   = cmp_idx_ff;
            min_cnt_in   = rd_cnt;
            min_page_in  = rd_page;
         end
      end

      unique case (state_ff)
         lfupr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               page_in      = PAGE_BITS'(req_page_number);
               hit_in       = 1'b0;
               min_valid_in = 1'b0;
               scan_idx_in  = '0;
               res_in       = '0;
               if (used_ff == '0) begin
                  shift_idx_in = '0;
                  state_in     = lfupr_pkg::ST_APPEND;
               end else begin
                  state_in = lfupr_pkg::ST_SCAN;
               end
            end
         end
         lfupr_pkg::ST_SCAN: begin
            mem_raddr      = scan_idx_ff;
            cmp_pending_in = 1'b1;
            cmp_idx_in     = scan_idx_ff;
            if (scan_last) begin
               state_in = lfupr_pkg::ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_BITS'(1);
            end
         end
         lfupr_pkg::ST_DRAIN: begin
            state_in = lfupr_pkg::ST_DECIDE;
         end
         lfupr_pkg::ST_DECIDE: begin
            res_in = '0;
            if (hit_ff) begin
               mem_we           = 1'b1;
               mem_waddr        = hit_idx_ff;
               mem_wdata        = {page_ff, cnt_sat};
               res_in.hit       = 1'b1;
               res_in.occupancy = lfupr_pkg::RSP_OCC_BITS'(used_ff);
               state_in         = lfupr_pkg::ST_RESP;
            end else if (!full) begin
               mem_we           = 1'b1;
               mem_waddr        = IDX_BITS'(used_ff);
               used_in          = used_inc;
               res_in.occupancy = lfupr_pkg::RSP_OCC_BITS'(used_inc);
               state_in         = lfupr_pkg::ST_RESP;
            end else begin
               res_in.evicted     = 1'b1;
               res_in.victim_page = lfupr_pkg::RSP_PAGE_BITS'(min_page_ff);
               res_in.occupancy   = lfupr_pkg::RSP_OCC_BITS'(used_ff);
               if (min_idx_ff == LAST_IDX) begin
                  mem_we    = 1'b1;
                  mem_waddr = LAST_IDX;
                  state_in  = lfupr_pkg::ST_RESP;
               end else begin
                  mem_raddr    = min_idx_ff + IDX_BITS'(1);
                  shift_idx_in = min_idx_ff;
                  state_in     = lfupr_pkg::ST_SHIFT;
               end
            end
         end
         lfupr_pkg::ST_SHIFT: begin
            // move the later entry down one place, fetch the one after it
            mem_we       = 1'b1;
            mem_waddr    = shift_idx_ff;
            mem_wdata    = mem_rdata;
            mem_raddr    = shift_next + IDX_BITS'(1);
            shift_idx_in = shift_next;
            if (shift_next == LAST_IDX) begin
               state_in = lfupr_pkg::ST_APPEND;
            end
         end
         lfupr_pkg::ST_APPEND: begin
            mem_we    = 1'b1;
            mem_waddr = shift_idx_ff;
            if (!full) begin
               used_in          = used_inc;
               res_in.occupancy = lfupr_pkg::RSP_OCC_BITS'(used_inc);
            end else begin
               res_in.occupancy = lfupr_pkg::RSP_OCC_BITS'(used_ff);
            end
            state_in = lfupr_pkg::ST_RESP;
         end
         lfupr_pkg::ST_RESP: begin
            res_valid = res_free;
            if (res_free) begin
               state_in = lfupr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfupr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
